@@ design/empirical_quantile_threshold_defines.svh @@
// ----------------------------------------------------------------------------
// empirical quantile threshold: assertion macros
// shared property wrappers, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef EMPIRICAL_QUANTILE_THRESHOLD_DEFINES_SVH
`define EMPIRICAL_QUANTILE_THRESHOLD_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define EQT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EQT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/eqt_pkg.sv @@
// ----------------------------------------------------------------------------
// eqt_pkg
// widths, reset values, register indexes and shared types of the
// empirical quantile threshold block
// ----------------------------------------------------------------------------
package eqt_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int HIT_W   = 16;
    localparam int TGT_W   = 16;
    localparam int RATIO_W = 32;
    localparam int CNT_W   = 11;
    localparam int TAIL_W  = 16;
    localparam int RANK_W  = 10;
    localparam int FRAC_W  = 16;
    localparam int QHI_W   = 2;
    localparam int PV_W    = QHI_W + FRAC_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FRACTION = 1'b1;
    localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RST  = 11'd1024;
    localparam logic [TAIL_W-1:0]    TAIL_FRACTION_RST = 16'd3277;

    localparam logic [RATIO_W-1:0] RATIO_MAX  = 32'hFFFF_FFFF;
    localparam logic [TAIL_W-1:0]  TAIL_ROUND = 16'hFFFF;

    // radix-16 restoring divider
    localparam int DIV_W       = 16;
    localparam int QUOT_W      = 32;
    localparam int DIV_STEP    = 4;
    localparam int RATIO_ITERS = QUOT_W / DIV_STEP;
    localparam int PV_ITERS    = FRAC_W / DIV_STEP;
    localparam int ITER_W      = $clog2(RATIO_ITERS + 1);

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    divisor;
        logic [DIV_W-1:0]    rem;      // starting partial remainder, below divisor
        logic [QUOT_W-1:0]   bits;     // dividend bits shifted in, msb first
        logic [ITER_W-1:0]   iters;
    } t_div_req;

    typedef struct packed {
        logic wr_en;
        logic sort_en;
        logic phase;
        logic inject;
    } t_cell_ctrl;

    // search token moving from the start cell toward cell 0
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [RATIO_W-1:0]  value;
        logic [CNT_W-1:0]    index;
    } t_lane;

endpackage

@@ design/eqt_cell.sv @@
// ----------------------------------------------------------------------------
// eqt_cell
// one storage cell of the ratio chain: holds one ratio, takes part in the
// odd-even transposition sort with its neighbors and forwards the search lane
// ----------------------------------------------------------------------------
module eqt_cell #(
    parameter int IDX    = 0,
    parameter int ADDR_W = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  eqt_pkg::t_cell_ctrl           i_ctrl,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic [eqt_pkg::RATIO_W-1:0]   i_wdata,
    input  logic [eqt_pkg::CNT_W-1:0]     i_n,
    input  logic [eqt_pkg::RATIO_W-1:0]   i_left_value,
    input  logic                          i_left_gt,
    input  logic [eqt_pkg::RATIO_W-1:0]   i_right_value,
    input  logic                          i_right_in_range,
    input  eqt_pkg::t_lane                i_right_lane,
    output logic [eqt_pkg::RATIO_W-1:0]   o_value,
    output logic                          o_gt,
    output logic                          o_in_range,
    output eqt_pkg::t_lane                o_lane
);

    localparam bit IDX_ODD    = ((IDX % 2) == 1);
    localparam bit HAS_LEFT   = (IDX > 0);
    localparam bit IDX_IN_CNT = (IDX < (1 << eqt_pkg::CNT_W));

    logic [eqt_pkg::RATIO_W-1:0] r_value;
    eqt_pkg::t_lane              r_lane;
    eqt_pkg::t_lane              n_lane;

    logic w_hit;
    logic w_gt;
    logic w_in_range;
    logic w_take_right;
    logic w_take_left;
    logic w_stop;

    assign w_hit      = (i_addr == ADDR_W'(IDX));
    assign w_gt       = (r_value > i_right_value);
    assign w_in_range = IDX_IN_CNT && (i_n > eqt_pkg::CNT_W'(IDX));

    // left member of an active pair takes the smaller, right member the larger
    assign w_take_right = i_ctrl.sort_en && (i_ctrl.phase == IDX_ODD)
                          && i_right_in_range && w_gt;
    assign w_take_left  = i_ctrl.sort_en && (i_ctrl.phase != IDX_ODD)
                          && HAS_LEFT && w_in_range && i_left_gt;

    // sorted region: a ratio differing from its lower neighbor ends the run
    assign w_stop = !HAS_LEFT || (r_value != i_left_value);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && w_hit) begin
            r_value <= i_wdata;
        end else if (w_take_right) begin
            r_value <= i_right_value;
        end else if (w_take_left) begin
            r_value <= i_left_value;
        end
    end

    always_comb begin
        n_lane = i_right_lane;
        if (i_ctrl.inject && w_hit) begin
            n_lane.valid = 1'b1;
            n_lane.found = 1'b0;
        end
        if (n_lane.valid && !n_lane.found && w_stop) begin
            n_lane.found = 1'b1;
            n_lane.value = r_value;
            n_lane.index = eqt_pkg::CNT_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_value    = r_value;
    assign o_gt       = w_gt;
    assign o_in_range = w_in_range;
    assign o_lane     = r_lane;

endmodule

@@ design/eqt_div.sv @@
// ----------------------------------------------------------------------------
// eqt_div
// iterative restoring divider, four quotient bits per cycle, shared by the
// ratio computation and the p-value computation
// ----------------------------------------------------------------------------
`include "empirical_quantile_threshold_defines.svh"

module eqt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eqt_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [eqt_pkg::QUOT_W-1:0]   o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [eqt_pkg::ITER_W-1:0]    r_cnt;
    logic [eqt_pkg::DIV_W-1:0]     r_div;
    logic [eqt_pkg::DIV_W-1:0]     r_rem;
    logic [eqt_pkg::QUOT_W-1:0]    r_bits;
    logic [eqt_pkg::QUOT_W-1:0]    r_quot;

    logic [eqt_pkg::DIV_W-1:0]     n_rem;
    logic [eqt_pkg::QUOT_W-1:0]    n_bits;
    logic [eqt_pkg::QUOT_W-1:0]    n_quot;

    always_comb begin
        logic [eqt_pkg::DIV_W:0]    v_trial;
        logic [eqt_pkg::DIV_W-1:0]  v_rem;
        logic [eqt_pkg::QUOT_W-1:0] v_bits;
        logic [eqt_pkg::QUOT_W-1:0] v_quot;
        v_rem  = r_rem;
        v_bits = r_bits;
        v_quot = r_quot;
        for (int k = 0; k < eqt_pkg::DIV_STEP; k++) begin
            v_trial = {v_rem, v_bits[eqt_pkg::QUOT_W-1]};
            v_bits  = {v_bits[eqt_pkg::QUOT_W-2:0], 1'b0};
            if (v_trial >= {1'b0, r_div}) begin
                v_rem  = eqt_pkg::DIV_W'(v_trial - {1'b0, r_div});
                v_quot = {v_quot[eqt_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                v_rem  = v_trial[eqt_pkg::DIV_W-1:0];
                v_quot = {v_quot[eqt_pkg::QUOT_W-2:0], 1'b0};
            end
        end
        n_rem  = v_rem;
        n_bits = v_bits;
        n_quot = v_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_div  <= i_req.divisor;
                r_rem  <= i_req.rem;
                r_bits <= i_req.bits;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_bits <= n_bits;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == eqt_pkg::ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `EQT_ASSERT_IMPL(a_start_when_free, i_req.start, !r_busy, "divider started while busy")
    `EQT_ASSERT_IMPL(a_busy_has_count, r_busy, r_cnt != '0, "divider busy with no steps left")

endmodule

@@ design/empirical_quantile_threshold.sv @@
// ----------------------------------------------------------------------------
// empirical_quantile_threshold
// collects overlap ratios of random samples in a chain of cells, sorts them
// after the last sample and reports the upper-tail threshold, its rank and
// its empirical p-value
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_ready    hit, target, last flag
//   out       source     o_out_valid / i_out_ready  overlap, rank, p-value
//   cfg       sink       i_cfg_we                   index, data
//
// a sample runs 8 iterations of the shared divider at four quotient bits per
// cycle, and skips the divider when the ratio saturates
// the last sample then adds the odd-even sort in the cell chain, the walk of
// the search token from the start cell down to cell 0 and the p-value division
// reset is synchronous; cell contents are not cleared and are valid once written
// a waiting result sits in the output register; input is taken only when idle,
// not while a sample is in work or the next result is ready behind it
// ----------------------------------------------------------------------------
`include "empirical_quantile_threshold_defines.svh"

module empirical_quantile_threshold #(
    parameter int MAX_SAMPLES = eqt_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [eqt_pkg::HIT_W-1:0]         i_hit_count,
    input  logic [eqt_pkg::TGT_W-1:0]         i_target_count,
    input  logic                              i_last_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [eqt_pkg::RATIO_W-1:0]       o_threshold_overlap,
    output logic [eqt_pkg::RANK_W-1:0]        o_threshold_rank,
    output logic [eqt_pkg::PV_W-1:0]          o_empirical_pvalue,
    input  logic                              i_cfg_we,
    input  logic [eqt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eqt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int FILL_W = $clog2(MAX_SAMPLES + 1);
    localparam int PROD_W = eqt_pkg::CNT_W + eqt_pkg::TAIL_W + 1;
    localparam int CUT_W  = PROD_W - eqt_pkg::TAIL_W;
    localparam int NUM_W  = eqt_pkg::CNT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_SORT,
        S_CUT,
        S_START,
        S_INJECT,
        S_SEARCH,
        S_PV,
        S_PVDIV,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [eqt_pkg::CNT_W-1:0]       r_sample_count;
    logic [eqt_pkg::TAIL_W-1:0]      r_tail_fraction;
    logic [FILL_W-1:0]               r_fill;
    logic                            r_last;
    logic                            r_sat;
    logic [eqt_pkg::CNT_W-1:0]       r_n;
    logic [eqt_pkg::CNT_W-1:0]       r_cnt;
    logic [CUT_W-1:0]                r_cut;
    logic [eqt_pkg::CNT_W-1:0]       r_start;
    logic [eqt_pkg::RATIO_W-1:0]     r_val;
    logic [eqt_pkg::CNT_W-1:0]       r_idx;
    logic [eqt_pkg::QHI_W-1:0]       r_qhi;
    logic                            r_out_valid;
    logic [eqt_pkg::RATIO_W-1:0]     r_out_overlap;
    logic [eqt_pkg::RANK_W-1:0]      r_out_rank;
    logic [eqt_pkg::PV_W-1:0]        r_out_pvalue;

    logic                            w_in_fire;
    logic                            w_emit;
    logic                            w_sat;
    logic [eqt_pkg::CNT_W-1:0]       w_n_clamped;
    logic [PROD_W-1:0]               w_cut_sum;
    logic [eqt_pkg::CNT_W-1:0]       w_n_m1;
    logic [eqt_pkg::CNT_W-1:0]       w_start;
    logic [NUM_W-1:0]                w_pv_num;
    logic [NUM_W-1:0]                w_n2;
    logic [NUM_W-1:0]                w_pv_rem;
    logic [eqt_pkg::QHI_W-1:0]       w_pv_qhi;
    logic [eqt_pkg::RATIO_W-1:0]     w_wdata;
    logic [AW-1:0]                   w_addr;
    eqt_pkg::t_cell_ctrl             w_ctrl;
    eqt_pkg::t_div_req               w_div_req;
    logic                            w_div_done;
    logic [eqt_pkg::QUOT_W-1:0]      w_div_quot;

    logic [eqt_pkg::RATIO_W-1:0]     w_value         [MAX_SAMPLES];
    logic                            w_gt            [MAX_SAMPLES];
    logic                            w_in_range      [MAX_SAMPLES];
    eqt_pkg::t_lane                  w_lane          [MAX_SAMPLES];
    logic [eqt_pkg::RATIO_W-1:0]     w_left_value    [MAX_SAMPLES];
    logic                            w_left_gt       [MAX_SAMPLES];
    logic [eqt_pkg::RATIO_W-1:0]     w_right_value   [MAX_SAMPLES];
    logic                            w_right_in_range[MAX_SAMPLES];
    eqt_pkg::t_lane                  w_right_lane    [MAX_SAMPLES];

    assign w_in_fire = i_in_valid && o_in_ready;
    assign w_emit    = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // quotient reaches 2^32 exactly when hit >= target * 256
    assign w_sat = (i_target_count == '0)
                   || ({8'b0, i_hit_count} >= {i_target_count, 8'b0});

    always_comb begin
        if (r_sample_count == '0) begin
            w_n_clamped = eqt_pkg::CNT_W'(1);
        end else if (32'(r_sample_count) > 32'(MAX_SAMPLES)) begin
            w_n_clamped = eqt_pkg::CNT_W'(MAX_SAMPLES);
        end else begin
            w_n_clamped = r_sample_count;
        end
    end

    // ceil(n * tail / 2^16)
    assign w_cut_sum = PROD_W'(r_n) * PROD_W'(r_tail_fraction)
                       + PROD_W'(eqt_pkg::TAIL_ROUND);

    assign w_n_m1  = r_n - 1'b1;
    assign w_start = (r_cut > CUT_W'(w_n_m1)) ? '0
                     : (w_n_m1 - r_cut[eqt_pkg::CNT_W-1:0]);

    // integer part of (n - idx + 1) / n is 0, 1 or 2
    assign w_pv_num = NUM_W'(r_n) - NUM_W'(r_idx) + NUM_W'(1);
    assign w_n2     = {r_n, 1'b0};

    always_comb begin
        if (w_pv_num >= w_n2) begin
            w_pv_qhi = eqt_pkg::QHI_W'(2);
            w_pv_rem = w_pv_num - w_n2;
        end else if (w_pv_num >= NUM_W'(r_n)) begin
            w_pv_qhi = eqt_pkg::QHI_W'(1);
            w_pv_rem = w_pv_num - NUM_W'(r_n);
        end else begin
            w_pv_qhi = '0;
            w_pv_rem = w_pv_num;
        end
    end

    assign w_wdata = r_sat ? eqt_pkg::RATIO_MAX : w_div_quot;

    always_comb begin
        w_div_req         = '0;
        w_div_req.divisor = i_target_count;
        w_div_req.rem     = {8'b0, i_hit_count[15:8]};
        w_div_req.bits    = {i_hit_count[7:0], 24'b0};
        w_div_req.iters   = eqt_pkg::ITER_W'(eqt_pkg::RATIO_ITERS);
        if (r_state == S_PV) begin
            w_div_req.start   = 1'b1;
            w_div_req.divisor = eqt_pkg::DIV_W'(r_n);
            w_div_req.rem     = eqt_pkg::DIV_W'(w_pv_rem);
            w_div_req.bits    = '0;
            w_div_req.iters   = eqt_pkg::ITER_W'(eqt_pkg::PV_ITERS);
        end else begin
            w_div_req.start = w_in_fire && !w_sat;
        end
    end

    always_comb begin
        w_ctrl = '0;
        w_addr = r_fill[AW-1:0];
        unique case (r_state)
            S_STORE: begin
                w_ctrl.wr_en = (r_fill < FILL_W'(MAX_SAMPLES));
            end
            S_SORT: begin
                w_ctrl.sort_en = 1'b1;
                w_ctrl.phase   = r_cnt[0];
            end
            S_INJECT: begin
                w_ctrl.inject = 1'b1;
                w_addr        = AW'(r_start);
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= eqt_pkg::SAMPLE_COUNT_RST;
            r_tail_fraction <= eqt_pkg::TAIL_FRACTION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eqt_pkg::REG_SAMPLE_COUNT: begin
                    r_sample_count <= i_cfg_data[eqt_pkg::CNT_W-1:0];
                end
                eqt_pkg::REG_TAIL_FRACTION: begin
                    r_tail_fraction <= i_cfg_data[eqt_pkg::TAIL_W-1:0];
                end
                default: begin
                    r_sample_count <= r_sample_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_last  <= i_last_sample;
                        r_sat   <= w_sat;
                        r_state <= w_sat ? S_STORE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (r_last) begin
                        r_fill  <= '0;
                        r_n     <= w_n_clamped;
                        r_cnt   <= '0;
                        r_state <= S_SORT;
                    end else begin
                        if (w_ctrl.wr_en) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SORT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == w_n_m1) begin
                        r_state <= S_CUT;
                    end
                end
                S_CUT: begin
                    r_cut   <= w_cut_sum[PROD_W-1:eqt_pkg::TAIL_W];
                    r_state <= S_START;
                end
                S_START: begin
                    r_start <= w_start;
                    r_state <= S_INJECT;
                end
                S_INJECT: begin
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (w_lane[0].valid) begin
                        r_val   <= w_lane[0].value;
                        r_idx   <= w_lane[0].index;
                        r_state <= S_PV;
                    end
                end
                S_PV: begin
                    r_qhi   <= w_pv_qhi;
                    r_state <= S_PVDIV;
                end
                S_PVDIV: begin
                    if (w_div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_overlap <= r_val;
                        r_out_rank    <= r_idx[eqt_pkg::RANK_W-1:0];
                        r_out_pvalue  <= {r_qhi, w_div_quot[eqt_pkg::FRAC_W-1:0]};
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    eqt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left_value[g] = '0;
            assign w_left_gt[g]    = 1'b0;
        end else begin : g_inner_left
            assign w_left_value[g] = w_value[g-1];
            assign w_left_gt[g]    = w_gt[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_last
            assign w_right_value[g]    = '0;
            assign w_right_in_range[g] = 1'b0;
            assign w_right_lane[g]     = '0;
        end else begin : g_inner_right
            assign w_right_value[g]    = w_value[g+1];
            assign w_right_in_range[g] = w_in_range[g+1];
            assign w_right_lane[g]     = w_lane[g+1];
        end

        eqt_cell #(
            .IDX    (g),
            .ADDR_W (AW)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (w_ctrl),
            .i_addr           (w_addr),
            .i_wdata          (w_wdata),
            .i_n              (r_n),
            .i_left_value     (w_left_value[g]),
            .i_left_gt        (w_left_gt[g]),
            .i_right_value    (w_right_value[g]),
            .i_right_in_range (w_right_in_range[g]),
            .i_right_lane     (w_right_lane[g]),
            .o_value          (w_value[g]),
            .o_gt             (w_gt[g]),
            .o_in_range       (w_in_range[g]),
            .o_lane           (w_lane[g])
        );
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_threshold_overlap = r_out_overlap;
    assign o_threshold_rank    = r_out_rank;
    assign o_empirical_pvalue  = r_out_pvalue;

    `EQT_ASSERT_IMPL(a_lane_in_search, w_lane[0].valid, r_state == S_SEARCH, "search token outside search")
    `EQT_ASSERT_IMPL(a_fill_bounded, 1'b1, r_fill <= FILL_W'(MAX_SAMPLES), "fill level beyond store depth")
    `EQT_ASSERT_IMPL(a_div_done_expected, w_div_done, r_state == S_DIV || r_state == S_PVDIV, "unexpected divider result")
    `EQT_ASSERT_NEXT(a_busy_after_accept, w_in_fire, r_state == S_DIV || r_state == S_STORE, "accepted transaction not in work")

endmodule

@@ verif/empirical_quantile_threshold_tb.sv @@
// ----------------------------------------------------------------------------
// empirical_quantile_threshold_tb
// self-checking bench: random samples go in over valid/ready, each last-sample
// transaction is predicted with an in-bench sort and tail search, and every
// threshold transaction out is compared field by field in arrival order
// ----------------------------------------------------------------------------
module empirical_quantile_threshold_tb;

    localparam int CLK_HALF      = 5;
    localparam int STALL_LIMIT   = 10000;
    localparam int ITEM_TARGET   = 1300;
    localparam int TARGET_TOP    = 32768;
    localparam int PHASE_GAP     = 40;
    localparam int SEND_IDLE_END = 5;    // phases with the sender idling less
    localparam int RECV_IDLE_END = 12;   // phases with the receiver idling less

    typedef struct packed {
        logic [eqt_pkg::HIT_W-1:0] hit;
        logic [eqt_pkg::TGT_W-1:0] target;
        logic                      last;
        logic                      drain;   // hold off until all thresholds are out
    } t_sample;

    typedef struct packed {
        logic [eqt_pkg::RATIO_W-1:0] overlap;
        logic [eqt_pkg::RANK_W-1:0]  rank;
        logic [eqt_pkg::PV_W-1:0]    pvalue;
    } t_threshold;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [eqt_pkg::HIT_W-1:0]      hit_r = '0;
    logic [eqt_pkg::TGT_W-1:0]      target_r = '0;
    logic                           last_r = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [eqt_pkg::RATIO_W-1:0]    overlap_o;
    logic [eqt_pkg::RANK_W-1:0]     rank_o;
    logic [eqt_pkg::PV_W-1:0]       pvalue_o;
    logic                           cfg_we = 1'b0;
    logic [eqt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [eqt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    t_sample    pending_samples[$];
    t_threshold predicted_thresholds[$];
    logic       in_took = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_cnt = 0;
    int         stall_cycles = 0;
    int         phase_no = 0;
    int         queued_items = 0;
    int         random_categories = 0;

    // shadow of the block state
    logic [eqt_pkg::RATIO_W-1:0] ratio_mem [eqt_pkg::MAX_SAMPLES_DEF];
    int                          fill_cnt = 0;
    logic [eqt_pkg::CNT_W-1:0]   count_cfg = eqt_pkg::SAMPLE_COUNT_RST;
    logic [eqt_pkg::TAIL_W-1:0]  tail_cfg = eqt_pkg::TAIL_FRACTION_RST;

    empirical_quantile_threshold uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_hit_count         (hit_r),
        .i_target_count      (target_r),
        .i_last_sample       (last_r),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_threshold_overlap (overlap_o),
        .o_threshold_rank    (rank_o),
        .o_empirical_pvalue  (pvalue_o),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // store one ratio and, on the last sample, predict the tail threshold
    task automatic absorb_sample(input logic [eqt_pkg::HIT_W-1:0] hit,
                                 input logic [eqt_pkg::TGT_W-1:0] tgt,
                                 input logic last);
        logic [63:0]                 quot;
        logic [eqt_pkg::RATIO_W-1:0] ratio;
        logic [eqt_pkg::RATIO_W-1:0] v;
        int                          n;
        int                          cut;
        int                          idx;
        int                          i;
        int                          j;
        int                          pv;
        t_threshold                  res;
        if (tgt == '0) begin
            ratio = eqt_pkg::RATIO_MAX;
        end else begin
            quot  = ({48'd0, hit} << 24) / {48'd0, tgt};
            ratio = (quot > 64'h0000_0000_FFFF_FFFF) ? eqt_pkg::RATIO_MAX : quot[31:0];
        end
        if (fill_cnt < eqt_pkg::MAX_SAMPLES_DEF) begin
            ratio_mem[fill_cnt] = ratio;
            fill_cnt++;
        end
        if (last) begin
            n = int'(count_cfg);
            if (n == 0) n = 1;
            if (n > eqt_pkg::MAX_SAMPLES_DEF) n = eqt_pkg::MAX_SAMPLES_DEF;
            for (i = 1; i < n; i++) begin
                v = ratio_mem[i];
                j = i;
                while (j > 0 && ratio_mem[j-1] > v) begin
                    ratio_mem[j] = ratio_mem[j-1];
                    j--;
                end
                ratio_mem[j] = v;
            end
            cut = (n * int'(tail_cfg) + 65535) >> 16;
            idx = (cut > n - 1) ? 0 : n - 1 - cut;
            // step down over ties
            while (idx > 0 && !(ratio_mem[idx] > ratio_mem[idx-1])) idx--;
            pv = ((n - idx + 1) << 16) / n;
            res.overlap = ratio_mem[idx];
            res.rank    = eqt_pkg::RANK_W'(idx);
            res.pvalue  = eqt_pkg::PV_W'(pv);
            predicted_thresholds = {predicted_thresholds, res};
            fill_cnt = 0;
        end
    endtask

    // result check, register shadow and prediction on every accepted transaction
    always @(posedge clk) begin
        t_threshold want;
        in_took <= in_valid && in_ready;
        if (!rst_n) begin
            fill_cnt  = 0;
            count_cfg = eqt_pkg::SAMPLE_COUNT_RST;
            tail_cfg  = eqt_pkg::TAIL_FRACTION_RST;
        end else begin
            if (out_valid && out_ready) begin
                if (predicted_thresholds.size() == 0) begin
                    $error("unexpected threshold: overlap %0h rank %0d pvalue %0h",
                           overlap_o, rank_o, pvalue_o);
                    fail_cnt++;
                end else begin
                    want = predicted_thresholds.pop_front();
                    if (overlap_o !== want.overlap) begin
                        $error("threshold_overlap: expected %0h, got %0h",
                               want.overlap, overlap_o);
                        fail_cnt++;
                    end
                    if (rank_o !== want.rank) begin
                        $error("threshold_rank: expected %0d, got %0d", want.rank, rank_o);
                        fail_cnt++;
                    end
                    if (pvalue_o !== want.pvalue) begin
                        $error("empirical_pvalue: expected %0h, got %0h",
                               want.pvalue, pvalue_o);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    eqt_pkg::REG_SAMPLE_COUNT:  count_cfg = cfg_data[eqt_pkg::CNT_W-1:0];
                    eqt_pkg::REG_TAIL_FRACTION: tail_cfg  = cfg_data[eqt_pkg::TAIL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) absorb_sample(hit_r, target_r, last_r);
        end
    end

    // sample driver
    always @(negedge clk) begin
        t_sample cur;
        if (rst_n && (!in_valid || in_took)) begin
            if (pending_samples.size() != 0 &&
                !(pending_samples[0].drain && predicted_thresholds.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
                cur = pending_samples.pop_front();
                in_valid <= 1'b1;
                hit_r    <= cur.hit;
                target_r <= cur.target;
                last_r   <= cur.last;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [eqt_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= eqt_pkg::CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for the block to go quiet, then reprogram it
    task automatic begin_phase(input int cnt, input int tail);
        while (pending_samples.size() != 0 || in_valid || predicted_thresholds.size() != 0)
            @(posedge clk);
        repeat (PHASE_GAP) @(posedge clk);
        if (phase_no < SEND_IDLE_END) begin
            send_idle_pct = 28;
            recv_idle_pct = 58;
        end else if (phase_no < RECV_IDLE_END) begin
            send_idle_pct = 58;
            recv_idle_pct = 28;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        phase_no++;
        write_reg(eqt_pkg::REG_SAMPLE_COUNT, cnt);
        write_reg(eqt_pkg::REG_TAIL_FRACTION, tail);
    endtask

    task automatic queue_sample(input int hit, input int tgt, input logic last,
                                input logic drain);
        t_sample s;
        s.hit    = eqt_pkg::HIT_W'(hit);
        s.target = eqt_pkg::TGT_W'(tgt);
        s.last   = last;
        s.drain  = drain;
        pending_samples = {pending_samples, s};
        queued_items++;
    endtask

    function automatic t_sample draw_sample(input int tie_pct);
        t_sample s;
        s.last   = 1'b0;
        s.drain  = 1'b0;
        s.hit    = eqt_pkg::HIT_W'($urandom_range(16'hFFFF));
        s.target = eqt_pkg::TGT_W'($urandom_range(1, TARGET_TOP));
        if ($urandom_range(99) < tie_pct) begin
            // few distinct ratios, lots of ties
            s.hit    = eqt_pkg::HIT_W'($urandom_range(3));
            s.target = eqt_pkg::TGT_W'($urandom_range(1, 2));
        end else begin
            case ($urandom_range(9))
                0: s.target = '0;
                1: s.target = eqt_pkg::TGT_W'($urandom_range(1, 255));
                2: s.target = eqt_pkg::TGT_W'(TARGET_TOP);
                3, 4: s.hit = eqt_pkg::HIT_W'($urandom_range(int'(s.target)));
                default: ;
            endcase
        end
        return s;
    endfunction

    task automatic queue_category(input int len, input int tie_pct, input logic drain_first);
        t_sample s;
        int      i;
        for (i = 0; i < len; i++) begin
            s = draw_sample(tie_pct);
            queue_sample(int'(s.hit), int'(s.target), i == len - 1, drain_first && i == 0);
        end
        random_categories++;
    endtask

    initial begin
        int cnt;
        int tail;
        int n_eff;
        int k;
        int parts;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-sample categories, then one of three samples: field extremes, zero target, overflow
        begin_phase(1, 0);
        queue_sample(0, 1, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 0, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1, 1'b1, 1'b0);
        queue_sample(0, TARGET_TOP, 1'b1, 1'b0);
        queue_sample(16'hFFFF, TARGET_TOP, 1'b1, 1'b0);
        queue_sample(16'h5555, 16'h7FFF, 1'b1, 1'b0);
        queue_sample(16'hAAAA, 16'h5555, 1'b1, 1'b0);
        queue_sample(256, 256, 1'b1, 1'b0);
        queue_sample(1, 1, 1'b1, 1'b0);
        queue_sample(7, 3, 1'b0, 1'b0);
        queue_sample(1, 2, 1'b0, 1'b0);
        queue_sample(9, 9, 1'b1, 1'b0);

        // zero count runs as one, tail too large
        begin_phase(0, 16'hFFFF);
        queue_sample(3, 4, 1'b1, 1'b0);
        queue_sample(0, 0, 1'b1, 1'b0);

        // all-equal ratios walk down to rank 0, then a short category
        begin_phase(4, 16'h8000);
        queue_sample(1, 2, 1'b0, 1'b0);
        queue_sample(2, 4, 1'b0, 1'b0);
        queue_sample(4, 8, 1'b0, 1'b0);
        queue_sample(3, 6, 1'b1, 1'b0);
        queue_sample(5, 1, 1'b0, 1'b1);
        queue_sample(1, 5, 1'b1, 1'b0);
        begin_phase(4, 1);
        queue_sample(100, 1, 1'b0, 1'b0);
        queue_sample(0, 0, 1'b0, 1'b0);
        queue_sample(2, 1, 1'b0, 1'b0);
        queue_sample(2, 1, 1'b1, 1'b0);

        // overfill the store so every entry has been written
        begin_phase(eqt_pkg::MAX_SAMPLES_DEF, int'(eqt_pkg::TAIL_FRACTION_RST));
        queue_category(eqt_pkg::MAX_SAMPLES_DEF + 6, 30, 1'b0);

        // count above the store size, only a few fresh samples
        begin_phase(2047, int'($urandom_range(16'hFFFF)));
        queue_category(5, 30, 1'b1);

        while (queued_items < ITEM_TARGET || random_categories < 40) begin
            case ($urandom_range(19))
                0: cnt = 0;
                1, 2: cnt = $urandom_range(25, 200);
                3: cnt = $urandom_range(1025, 2047);
                default: cnt = $urandom_range(1, 24);
            endcase
            case ($urandom_range(5))
                0: tail = 0;
                1: tail = 16'hFFFF;
                2: tail = $urandom_range(1, 4096);
                default: tail = $urandom_range(16'hFFFF);
            endcase
            n_eff = (cnt == 0) ? 1
                    : (cnt > eqt_pkg::MAX_SAMPLES_DEF) ? eqt_pkg::MAX_SAMPLES_DEF : cnt;
            begin_phase(cnt, tail);
            parts = $urandom_range(1, 4);
            for (k = 0; k < parts; k++)
                queue_category($urandom_range(1, (n_eff < 40 ? n_eff : 40) + 4),
                               $urandom_range(0, 1) * 40, $urandom_range(7) == 0);
        end

        while (pending_samples.size() != 0 || in_valid || predicted_thresholds.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
